@@ rtl/core/sms_pkg.sv @@
// Shared types, codes and reset constants of the motor sway sequencer.
`default_nettype none

package sms_pkg;

  localparam int unsigned TimeW   = 16;
  localparam int unsigned CfgIdxW = 3;

  typedef logic [TimeW-1:0]   time_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  typedef logic [1:0]         cmd_t;
  typedef logic [1:0]         mode_t;
  typedef logic [1:0]         drive_t;
  typedef logic [2:0]         phase_t;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_SET  = 2'd1,
    CMD_STOP = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_SWAY  = 2'd1,
    MODE_NOD   = 2'd2,
    MODE_DANCE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    DRV_STOP = 2'd0,
    DRV_FWD  = 2'd1,
    DRV_REV  = 2'd2
  } drive_e;

  typedef enum logic [2:0] {
    PH_WAIT_FWD = 3'd0,
    PH_FWD      = 3'd1,
    PH_REST_FWD = 3'd2,
    PH_WAIT_REV = 3'd3,
    PH_REV      = 3'd4,
    PH_REST_REV = 3'd5
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FWD_TIME      = 3'd0,
    CFG_FWD_REST_TIME = 3'd1,
    CFG_REV_TIME      = 3'd2,
    CFG_REV_REST_TIME = 3'd3,
    CFG_MAX_ENERGIZED = 3'd4
  } cfg_idx_e;

  localparam time_t FwdTimeRst      = 16'd500;
  localparam time_t FwdRestTimeRst  = 16'd700;
  localparam time_t RevTimeRst      = 16'd500;
  localparam time_t RevRestTimeRst  = 16'd1200;
  localparam time_t MaxEnergizedRst = 16'd2000;

endpackage

`default_nettype wire

@@ rtl/core/sms_if.sv @@
// Handshake channels of the motor sway sequencer: input, result and configuration.
`default_nettype none

interface sms_in_if;
  import sms_pkg::*;
  logic   valid;
  logic   ready;
  cmd_t   command;
  mode_t  new_mode;
  logic   power_ready;

  modport source (output valid, command, new_mode, power_ready, input ready);
  modport sink   (input valid, command, new_mode, power_ready, output ready);
endinterface

interface sms_out_if;
  import sms_pkg::*;
  logic   valid;
  logic   ready;
  drive_t drive;
  logic   power_request;
  logic   power_release;
  logic   power_release_now;
  logic   safety_trip;
  mode_t  mode_now;
  phase_t phase_now;

  modport source (output valid, drive, power_request, power_release, power_release_now,
                  safety_trip, mode_now, phase_now, input ready);
  modport sink   (input valid, drive, power_request, power_release, power_release_now,
                  safety_trip, mode_now, phase_now, output ready);
endinterface

interface sms_cfg_if;
  import sms_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  time_t    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/motor_sway_sequencer.sv @@
// Motor sway sequencer: mode, six-phase sway sequence, watchdog and result register.
`default_nettype none

// Takes one beat per clock: a millisecond tick, a set-mode command or a stop command.
// The state update and the result are formed combinationally from the mode, phase and
// elapsed-time registers; the result sits in a single output register and appears in
// the cycle after its beat is accepted. The input is ready whenever that register is
// empty or being emptied in the same cycle, so with a ready sink the block sustains one
// item per cycle. Configuration writes are always taken and act from the next item.
module motor_sway_sequencer (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sms_cfg_if.sink   cfg_i,
  sms_in_if.sink    in_i,
  sms_out_if.source out_o
);
  import sms_pkg::*;

  time_t  fwd_time_q, fwd_rest_time_q, rev_time_q, rev_rest_time_q, max_energized_q;

  mode_t  mode_q, mode_d;
  phase_t phase_q, phase_d;
  time_t  phase_elapsed_q, phase_elapsed_d;
  logic   energized_q, energized_d;
  time_t  energized_elapsed_q, energized_elapsed_d;
  drive_t drive_q, drive_d;

  logic   req_d, rel_d, rel_now_d, trip_d;

  logic   out_valid_q;
  drive_t out_drive_q;
  logic   out_req_q, out_rel_q, out_rel_now_q, out_trip_q;
  mode_t  out_mode_q;
  phase_t out_phase_q;

  logic   in_fire;
  logic   out_free;

  function automatic time_t sat_inc(time_t v);
    return (v == '1) ? v : time_t'(v + time_t'(1));
  endfunction

  assign cfg_i.ready = 1'b1;
  assign out_free    = !out_valid_q || out_o.ready;
  assign in_i.ready  = out_free;
  assign in_fire     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_time_q      <= FwdTimeRst;
      fwd_rest_time_q <= FwdRestTimeRst;
      rev_time_q      <= RevTimeRst;
      rev_rest_time_q <= RevRestTimeRst;
      max_energized_q <= MaxEnergizedRst;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        CFG_FWD_TIME:      fwd_time_q      <= cfg_i.data;
        CFG_FWD_REST_TIME: fwd_rest_time_q <= cfg_i.data;
        CFG_REV_TIME:      rev_time_q      <= cfg_i.data;
        CFG_REV_REST_TIME: rev_rest_time_q <= cfg_i.data;
        CFG_MAX_ENERGIZED: max_energized_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    mode_d              = mode_q;
    phase_d             = phase_q;
    phase_elapsed_d     = phase_elapsed_q;
    energized_d         = energized_q;
    energized_elapsed_d = energized_elapsed_q;
    drive_d             = drive_q;
    req_d               = 1'b0;
    rel_d               = 1'b0;
    rel_now_d           = 1'b0;
    trip_d              = 1'b0;

    unique case (in_i.command)
      CMD_TICK: begin
        phase_elapsed_d = sat_inc(phase_elapsed_q);
        if (energized_q) begin
          energized_elapsed_d = sat_inc(energized_elapsed_q);
        end
        // watchdog: stop the drive but leave the phase to run out on its own time
        if (energized_q && energized_elapsed_d >= max_energized_q) begin
          drive_d     = DRV_STOP;
          energized_d = 1'b0;
          rel_now_d   = 1'b1;
          trip_d      = 1'b1;
        end
        if (mode_q == MODE_SWAY) begin
          unique case (phase_q)
            PH_FWD: begin
              if (phase_elapsed_d >= fwd_time_q) begin
                drive_d         = DRV_STOP;
                energized_d     = 1'b0;
                rel_d           = 1'b1;
                phase_d         = PH_REST_FWD;
                phase_elapsed_d = '0;
              end
            end
            PH_REST_FWD: begin
              if (phase_elapsed_d >= fwd_rest_time_q) begin
                phase_d         = PH_WAIT_REV;
                phase_elapsed_d = '0;
                req_d           = 1'b1;
              end
            end
            PH_WAIT_REV: begin
              if (in_i.power_ready) begin
                drive_d             = DRV_REV;
                energized_d         = 1'b1;
                energized_elapsed_d = '0;
                phase_d             = PH_REV;
                phase_elapsed_d     = '0;
              end
            end
            PH_REV: begin
              if (phase_elapsed_d >= rev_time_q) begin
                drive_d         = DRV_STOP;
                energized_d     = 1'b0;
                rel_d           = 1'b1;
                phase_d         = PH_REST_REV;
                phase_elapsed_d = '0;
              end
            end
            PH_REST_REV: begin
              if (phase_elapsed_d >= rev_rest_time_q) begin
                phase_d         = PH_WAIT_FWD;
                phase_elapsed_d = '0;
                req_d           = 1'b1;
              end
            end
            // wait forward, and the unreachable codes treated alike
            default: begin
              if (in_i.power_ready) begin
                drive_d             = DRV_FWD;
                energized_d         = 1'b1;
                energized_elapsed_d = '0;
                phase_d             = PH_FWD;
                phase_elapsed_d     = '0;
              end
            end
          endcase
        end
      end
      CMD_SET: begin
        drive_d     = DRV_STOP;
        energized_d = 1'b0;
        rel_now_d   = 1'b1;
        mode_d      = in_i.new_mode;
        if (in_i.new_mode == MODE_SWAY) begin
          phase_d         = PH_WAIT_FWD;
          phase_elapsed_d = '0;
          req_d           = 1'b1;
        end
      end
      CMD_STOP: begin
        drive_d     = DRV_STOP;
        energized_d = 1'b0;
        rel_now_d   = 1'b1;
        mode_d      = MODE_OFF;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q              <= MODE_OFF;
      phase_q             <= PH_WAIT_FWD;
      phase_elapsed_q     <= '0;
      energized_q         <= 1'b0;
      energized_elapsed_q <= '0;
      drive_q             <= DRV_STOP;
    end else if (in_fire) begin
      mode_q              <= mode_d;
      phase_q             <= phase_d;
      phase_elapsed_q     <= phase_elapsed_d;
      energized_q         <= energized_d;
      energized_elapsed_q <= energized_elapsed_d;
      drive_q             <= drive_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_fire;
    end
  end

  // result payload: load on every accepted beat, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_drive_q   <= drive_d;
      out_req_q     <= req_d;
      out_rel_q     <= rel_d;
      out_rel_now_q <= rel_now_d;
      out_trip_q    <= trip_d;
      out_mode_q    <= mode_d;
      out_phase_q   <= phase_d;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.drive             = out_drive_q;
  assign out_o.power_request     = out_req_q;
  assign out_o.power_release     = out_rel_q;
  assign out_o.power_release_now = out_rel_now_q;
  assign out_o.safety_trip       = out_trip_q;
  assign out_o.mode_now          = out_mode_q;
  assign out_o.phase_now         = out_phase_q;

  a_drive_means_energized: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (drive_q != DRV_STOP) == energized_q)
    else $error("drive and energized flag disagree");

  a_phase_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PH_REST_REV)
    else $error("sway phase left its range");

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted beat produced no result");

  a_phase_frozen_outside_sway: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.command == CMD_TICK && mode_q != MODE_SWAY) |=> $stable(phase_q))
    else $error("phase moved outside sway mode");

  a_trip_releases_now: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && trip_d) |=> (out_rel_now_q && out_drive_q == DRV_STOP))
    else $error("watchdog trip without immediate release and stop");

endmodule

`default_nettype wire

@@ tb/sv/sms_result_checker.sv @@
// Monitors the sequencer channels, predicts every result beat and compares it on arrival.
module sms_result_checker
  import sms_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  sms_in_if           in_mon_i,
  sms_out_if          out_mon_i,
  sms_cfg_if          cfg_mon_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    drive_t drive;
    logic   power_request;
    logic   power_release;
    logic   power_release_now;
    logic   safety_trip;
    mode_t  mode_now;
    phase_t phase_now;
  } sway_result_t;

  // Timing registers as last written
  time_t fwd_time_q;
  time_t fwd_rest_q;
  time_t rev_time_q;
  time_t rev_rest_q;
  time_t max_energized_q;

  // Predicted sequencer state
  mode_t  mode_q;
  phase_t phase_q;
  time_t  phase_ms_q;
  logic   energized_q;
  time_t  energized_ms_q;
  drive_t drive_q;

  sway_result_t expected_q[$];

  function automatic time_t count_ms(time_t ms);
    return (ms == '1) ? ms : time_t'(ms + time_t'(1));
  endfunction

  function automatic void cut_drive();
    drive_q     = DRV_STOP;
    energized_q = 1'b0;
  endfunction

  function automatic void enter_phase(phase_t ph);
    phase_q    = ph;
    phase_ms_q = '0;
  endfunction

  function automatic void switch_on(drive_t dir);
    drive_q        = dir;
    energized_q    = 1'b1;
    energized_ms_q = '0;
  endfunction

  function automatic sway_result_t step_sequencer(cmd_t cmd, mode_t new_mode, logic power_ok);
    sway_result_t res;
    res = '0;
    case (cmd)
      CMD_TICK: begin
        phase_ms_q = count_ms(phase_ms_q);
        if (energized_q) energized_ms_q = count_ms(energized_ms_q);
        // watchdog stops the motor but leaves the phase to run out on its own
        if (energized_q && energized_ms_q >= max_energized_q) begin
          cut_drive();
          res.power_release_now = 1'b1;
          res.safety_trip       = 1'b1;
        end
        if (mode_q == MODE_SWAY) begin
          case (phase_q)
            PH_FWD: begin
              if (phase_ms_q >= fwd_time_q) begin
                cut_drive();
                res.power_release = 1'b1;
                enter_phase(PH_REST_FWD);
              end
            end
            PH_REST_FWD: begin
              if (phase_ms_q >= fwd_rest_q) begin
                enter_phase(PH_WAIT_REV);
                res.power_request = 1'b1;
              end
            end
            PH_WAIT_REV: begin
              if (power_ok) begin
                switch_on(DRV_REV);
                enter_phase(PH_REV);
              end
            end
            PH_REV: begin
              if (phase_ms_q >= rev_time_q) begin
                cut_drive();
                res.power_release = 1'b1;
                enter_phase(PH_REST_REV);
              end
            end
            PH_REST_REV: begin
              if (phase_ms_q >= rev_rest_q) begin
                enter_phase(PH_WAIT_FWD);
                res.power_request = 1'b1;
              end
            end
            default: begin
              if (power_ok) begin
                switch_on(DRV_FWD);
                enter_phase(PH_FWD);
              end
            end
          endcase
        end
      end
      CMD_SET: begin
        cut_drive();
        res.power_release_now = 1'b1;
        mode_q = new_mode;
        if (new_mode == MODE_SWAY) begin
          enter_phase(PH_WAIT_FWD);
          res.power_request = 1'b1;
        end
      end
      CMD_STOP: begin
        cut_drive();
        res.power_release_now = 1'b1;
        mode_q = MODE_OFF;
      end
      default: ;
    endcase
    res.drive     = drive_q;
    res.mode_now  = mode_q;
    res.phase_now = phase_q;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sway_result_t got;
    sway_result_t want;
    if (!rst_ni) begin
      fwd_time_q      = FwdTimeRst;
      fwd_rest_q      = FwdRestTimeRst;
      rev_time_q      = RevTimeRst;
      rev_rest_q      = RevRestTimeRst;
      max_energized_q = MaxEnergizedRst;
      mode_q          = MODE_OFF;
      phase_q         = PH_WAIT_FWD;
      phase_ms_q      = '0;
      energized_q     = 1'b0;
      energized_ms_q  = '0;
      drive_q         = DRV_STOP;
      expected_q.delete();
      fail_count_o    = 0;
      pending_o       = 0;
    end else begin
      if (cfg_mon_i.valid && cfg_mon_i.ready) begin
        case (cfg_mon_i.index)
          CFG_FWD_TIME:      fwd_time_q      = cfg_mon_i.data;
          CFG_FWD_REST_TIME: fwd_rest_q      = cfg_mon_i.data;
          CFG_REV_TIME:      rev_time_q      = cfg_mon_i.data;
          CFG_REV_REST_TIME: rev_rest_q      = cfg_mon_i.data;
          CFG_MAX_ENERGIZED: max_energized_q = cfg_mon_i.data;
          default: ;
        endcase
      end

      if (out_mon_i.valid && out_mon_i.ready) begin
        got = '{drive:             out_mon_i.drive,
                power_request:     out_mon_i.power_request,
                power_release:     out_mon_i.power_release,
                power_release_now: out_mon_i.power_release_now,
                safety_trip:       out_mon_i.safety_trip,
                mode_now:          out_mon_i.mode_now,
                phase_now:         out_mon_i.phase_now};
        if (expected_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= MaxReports)
            $display({"%0t: result beat with nothing expected: ",
                      "drive %0d req %0b rel %0b now %0b trip %0b mode %0d phase %0d"},
                     $realtime, got.drive, got.power_request, got.power_release,
                     got.power_release_now, got.safety_trip, got.mode_now, got.phase_now);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            fail_count_o++;
            if (fail_count_o <= MaxReports)
              $display({"%0t: result mismatch, expected ",
                        "drive %0d req %0b rel %0b now %0b trip %0b mode %0d phase %0d, got ",
                        "drive %0d req %0b rel %0b now %0b trip %0b mode %0d phase %0d"},
                       $realtime,
                       want.drive, want.power_request, want.power_release,
                       want.power_release_now, want.safety_trip, want.mode_now,
                       want.phase_now,
                       got.drive, got.power_request, got.power_release,
                       got.power_release_now, got.safety_trip, got.mode_now,
                       got.phase_now);
          end
        end
      end

      if (in_mon_i.valid && in_mon_i.ready)
        expected_q.push_back(step_sequencer(in_mon_i.command, in_mon_i.new_mode,
                                            in_mon_i.power_ready));
      pending_o = expected_q.size();
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
// Top of the sequencer bench: clock, reset, directed and random beats, timing settings, verdict.
module testbench;
  import sms_pkg::*;

  localparam cmd_t        CmdUnused = 2'd3;
  localparam int unsigned WaitCeil  = 17;
  localparam time_t       TimeMax   = 16'hFFFF;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned src_ceil  = WaitCeil;
  int unsigned sink_ceil = WaitCeil;

  sms_in_if  in_ch();
  sms_out_if out_ch();
  sms_cfg_if cfg_ch();

  motor_sway_sequencer dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_ch),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  sms_result_checker result_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_mon_i     (in_ch),
    .out_mon_i    (out_ch),
    .cfg_mon_i    (cfg_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk = ~clk;

  function automatic int unsigned draw_wait(int unsigned ceil_v);
    return (ceil_v == 0) ? 0 : $urandom_range(ceil_v, 0);
  endfunction

  // Entered and left at a falling edge; valid stays high when the next beat follows at once
  task automatic send_beat(cmd_t cmd, mode_t new_mode, logic power_ok);
    int unsigned gap;
    gap = draw_wait(src_ceil);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= cmd;
    in_ch.new_mode    <= new_mode;
    in_ch.power_ready <= power_ok;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    @(negedge clk);
  endtask

  // Drop valid and hold until every predicted beat has come back
  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic cfg_beat(cfg_idx_e idx, time_t value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    @(negedge clk);
  endtask

  task automatic write_settings(time_t fwd, time_t fwd_rest, time_t rev, time_t rev_rest,
                                time_t max_on);
    cfg_beat(CFG_FWD_TIME, fwd);
    cfg_beat(CFG_FWD_REST_TIME, fwd_rest);
    cfg_beat(CFG_REV_TIME, rev);
    cfg_beat(CFG_REV_REST_TIME, rev_rest);
    cfg_beat(CFG_MAX_ENERGIZED, max_on);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic time_t draw_duration();
    int unsigned r;
    r = $urandom_range(9, 0);
    if (r == 0) return '0;
    if (r == 1) return TimeMax;
    return time_t'($urandom_range(12, 1));
  endfunction

  // Mostly ticks so the sway sequence gets deep; the rest are commands and noise
  task automatic run_random(int unsigned beats, int unsigned tick_permille);
    int unsigned r;
    src_ceil  = ($urandom_range(2, 0) == 0) ? 0 : WaitCeil;
    sink_ceil = ($urandom_range(2, 0) == 0) ? 0 : WaitCeil;
    send_beat(CMD_SET, MODE_SWAY, 1'($urandom_range(1, 0)));
    repeat (beats) begin
      if ($urandom_range(199, 0) == 0) wait_drain();
      if ($urandom_range(999, 0) < tick_permille) begin
        send_beat(CMD_TICK, mode_t'($urandom_range(3, 0)), $urandom_range(3, 0) != 0);
      end else begin
        r = $urandom_range(9, 0);
        if (r < 4)
          send_beat(CMD_SET, MODE_SWAY, 1'($urandom_range(1, 0)));
        else if (r < 6)
          send_beat(CMD_SET, mode_t'($urandom_range(3, 0)), 1'($urandom_range(1, 0)));
        else if (r < 9)
          send_beat(CMD_STOP, mode_t'($urandom_range(3, 0)), 1'($urandom_range(1, 0)));
        else
          send_beat(CmdUnused, mode_t'($urandom_range(3, 0)), 1'($urandom_range(1, 0)));
      end
    end
  endtask

  // Result side: stall for a drawn number of cycles after each beat taken
  initial begin
    int unsigned hold;
    hold         = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold != 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
      end
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) hold = draw_wait(sink_ceil);
    end
  end

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.command     = CMD_TICK;
    in_ch.new_mode    = MODE_OFF;
    in_ch.power_ready = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = CFG_FWD_TIME;
    cfg_ch.data       = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Reset timings: every command and mode, unused command, mode change while driving
    send_beat(CmdUnused, MODE_DANCE, 1'b1);
    send_beat(CMD_TICK, MODE_OFF, 1'b1);
    send_beat(CMD_SET, MODE_NOD, 1'b0);
    send_beat(CMD_SET, MODE_DANCE, 1'b1);
    send_beat(CMD_TICK, MODE_SWAY, 1'b1);
    send_beat(CMD_STOP, MODE_DANCE, 1'b1);
    send_beat(CMD_SET, MODE_OFF, 1'b0);
    send_beat(CMD_SET, MODE_SWAY, 1'b1);
    send_beat(CMD_TICK, MODE_OFF, 1'b0);
    send_beat(CMD_TICK, MODE_OFF, 1'b1);
    send_beat(CmdUnused, MODE_SWAY, 1'b0);
    send_beat(CMD_TICK, MODE_OFF, 1'b0);
    send_beat(CMD_SET, MODE_NOD, 1'b1);
    send_beat(CMD_TICK, MODE_OFF, 1'b1);

    // Long run on the reset timings, long enough for the forward segment to end
    run_random(650, 998);
    wait_drain();

    // Zero durations and zero watchdog limit: phases end and trips fire on the first tick
    write_settings('0, '0, '0, '0, '0);
    send_beat(CMD_SET, MODE_SWAY, 1'b0);
    send_beat(CMD_TICK, MODE_DANCE, 1'b1);
    send_beat(CMD_TICK, MODE_DANCE, 1'b0);
    send_beat(CMD_TICK, MODE_NOD, 1'b0);
    send_beat(CMD_TICK, MODE_NOD, 1'b0);
    send_beat(CMD_TICK, MODE_OFF, 1'b1);
    send_beat(CMD_TICK, MODE_OFF, 1'b1);
    send_beat(CMD_TICK, MODE_OFF, 1'b1);
    send_beat(CMD_TICK, MODE_OFF, 1'b1);
    send_beat(CMD_STOP, MODE_SWAY, 1'b1);
    run_random(150, 900);
    wait_drain();

    write_settings(TimeMax, TimeMax, TimeMax, TimeMax, TimeMax);
    run_random(80, 950);

    repeat (7) begin
      wait_drain();
      write_settings(draw_duration(), draw_duration(), draw_duration(), draw_duration(),
                     ($urandom_range(7, 0) == 0) ? TimeMax : time_t'($urandom_range(15, 0)));
      run_random(160, 900);
    end

    wait_drain();
    repeat (4) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/sms_pkg.sv
rtl/core/sms_if.sv
rtl/core/motor_sway_sequencer.sv
tb/sv/sms_result_checker.sv
tb/sv/testbench.sv
